### sv/tmp_pkg.sv
// ----------------------------------------------------------------------------
// tmp_pkg: shared types, codes and helpers for the trapezoidal motion profile
// Q16.16 fixed point throughout; plan record passed from planner to evaluator.
// ----------------------------------------------------------------------------
package tmp_pkg;

    // register indexes on the configuration channel
    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_START = 3'd1;
    localparam logic [2:0] CFG_END   = 3'd2;
    localparam logic [2:0] CFG_ACCEL = 3'd3;
    localparam logic [2:0] CFG_DECEL = 3'd4;
    localparam logic [2:0] CFG_PEAK  = 3'd5;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        SEC_BEFORE = 3'd0,
        SEC_ACCEL  = 3'd1,
        SEC_CRUISE = 3'd2,
        SEC_DECEL  = 3'd3,
        SEC_DONE   = 3'd4
    } t_section;

    typedef enum logic [4:0] {
        PS_IDLE,
        PS_START,
        PS_TA0,
        PS_TD0,
        PS_SMUL,
        PS_CHECK,
        PS_TC,
        PS_ARMUL,
        PS_H,
        PS_DHMUL,
        PS_SQRT,
        PS_TA1,
        PS_TD1,
        PS_M1_MUL,
        PS_M1_TA,
        PS_M1_CHECK,
        PS_VC,
        PS_ACC,
        PS_DEC,
        PS_FIN,
        PS_BASE1,
        PS_BASE2,
        PS_BASE3
    } t_plan_state;

    typedef struct packed {
        logic [30:0]        ta;
        logic [30:0]        ds;
        logic [30:0]        tot;
        logic [30:0]        acc;
        logic [30:0]        dec;
        logic [30:0]        vc;
        logic [30:0]        base;   // position gained over the accel section
        logic               err;
        logic               neg;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
    } t_plan;

    function automatic logic [30:0] sat31(input logic [63:0] x);
        logic [30:0] y;
        y = (|x[63:31]) ? MAX31 : x[30:0];
        return y;
    endfunction

    function automatic logic [31:0] sat32u(input logic [63:0] x);
        logic [31:0] y;
        y = (|x[63:32]) ? 32'hFFFF_FFFF : x[31:0];
        return y;
    endfunction

    function automatic logic [31:0] sat32s(input logic signed [34:0] x);
        logic [31:0] y;
        if (x > 35'sh0_7FFF_FFFF) begin
            y = 32'h7FFF_FFFF;
        end else if (x < -35'sh0_8000_0000) begin
            y = 32'h8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

### sv/tmp_if.sv
// ----------------------------------------------------------------------------
// tmp_if: valid/ready channels of the trapezoidal motion profile
// Sample channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tmp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_time;
    modport source(output valid, output sample_time, input ready);
    modport sink(input valid, input sample_time, output ready);
endinterface

interface tmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] accel_value;
    logic [30:0]        clamped_time;
    logic [2:0]         section;
    logic [30:0]        total_duration;
    logic [30:0]        cruise_start;
    logic [30:0]        decel_start;
    logic               plan_error;
    modport source(output valid, output position, output velocity, output accel_value,
                   output clamped_time, output section, output total_duration,
                   output cruise_start, output decel_start, output plan_error,
                   input ready);
    modport sink(input valid, input position, input velocity, input accel_value,
                 input clamped_time, input section, input total_duration,
                 input cruise_start, input decel_start, input plan_error,
                 output ready);
endinterface

interface tmp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

### sv/tmp_div.sv
// ----------------------------------------------------------------------------
// tmp_div: restoring divider, 64-bit dividend by 32-bit divisor
// One quotient bit per cycle; done pulses when the last quotient bit is registered.
// ----------------------------------------------------------------------------
module tmp_div
    import tmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;

    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] n_rem;

    always_comb begin
        sh    = {r_rem, r_q[63]};
        diff  = sh - {1'b0, r_dvs};
        ge    = (sh >= {1'b0, r_dvs});
        n_rem = ge ? diff[31:0] : sh[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### sv/tmp_sqrt.sv
// ----------------------------------------------------------------------------
// tmp_sqrt: integer square root of a 64-bit value
// Digit by digit, two radicand bits per cycle; floor result.
// ----------------------------------------------------------------------------
module tmp_sqrt
    import tmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_x;
    logic [33:0] r_rem;
    logic [31:0] r_root;

    logic [35:0] sh;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] diff;

    always_comb begin
        sh    = {r_rem, r_x[63:62]};
        trial = {2'b00, r_root, 2'b01};
        ge    = (sh >= trial);
        diff  = sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= ge ? diff[33:0] : sh[33:0];
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### sv/tmp_plan.sv
// ----------------------------------------------------------------------------
// tmp_plan: configuration registers and move planner
// Sequencer over one shared divider, square root unit and multiplier; it
// reruns after reset and after every configuration write.
// ----------------------------------------------------------------------------
module tmp_plan
    import tmp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmp_cfg_if.sink       i_cfg,
    output t_plan         o_plan,
    output logic          o_plan_ok
);

    // configuration
    logic               r_mode;
    logic signed [31:0] r_p0;
    logic signed [31:0] r_p1;
    logic [30:0]        r_a;
    logic [30:0]        r_r;
    logic [30:0]        r_v;

    // plan datapath
    t_plan_state r_state;
    t_plan_state n_state;
    logic        r_issued;
    logic [30:0] r_ta, r_td, r_tc, r_ds, r_tot, r_acc, r_dec, r_h, r_base;
    logic [31:0] r_vc;
    logic        r_err;
    logic [63:0] r_prod;

    logic        cfg_wr;
    logic [32:0] diff;
    logic        neg;
    logic [31:0] d;
    logic [31:0] a_plus_r;
    logic [31:0] ta_plus_td;
    logic        m1_fit;

    logic        is_div, is_sqrt, is_mul;
    logic [63:0] div_dvd;
    logic [31:0] div_dvs;
    logic [31:0] mul_a, mul_b;
    logic        div_done, sqrt_done, op_done;
    logic [63:0] div_q;
    logic [31:0] sqrt_root;
    logic [30:0] q31;

    logic [31:0] ds_sum, tot_sum;
    logic [30:0] fin_ds, fin_tot;
    logic [31:0] base_q;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_p0   <= '0;
            r_p1   <= '0;
            r_a    <= '0;
            r_r    <= '0;
            r_v    <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                CFG_MODE:  r_mode <= i_cfg.data[0];
                CFG_START: r_p0   <= i_cfg.data;
                CFG_END:   r_p1   <= i_cfg.data;
                CFG_ACCEL: r_a    <= i_cfg.data[30:0];
                CFG_DECEL: r_r    <= i_cfg.data[30:0];
                CFG_PEAK:  r_v    <= i_cfg.data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        diff       = {r_p1[31], r_p1} - {r_p0[31], r_p0};
        neg        = diff[32];
        d          = neg ? 32'(-diff) : diff[31:0];
        a_plus_r   = {1'b0, r_a} + {1'b0, r_r};
        ta_plus_td = {1'b0, r_ta} + {1'b0, r_td};
        m1_fit     = (a_plus_r <= {1'b0, r_v});
        q31        = sat31(div_q);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            PS_IDLE:  n_state = PS_IDLE;
            PS_START: begin
                if (!r_mode) begin
                    n_state = (r_a == '0 || r_r == '0 || r_v == '0) ? PS_FIN : PS_TA0;
                end else begin
                    n_state = m1_fit ? PS_M1_CHECK : PS_M1_MUL;
                end
            end
            PS_TA0:      if (op_done) n_state = PS_TD0;
            PS_TD0:      if (op_done) n_state = PS_SMUL;
            PS_SMUL:     n_state = PS_CHECK;
            PS_CHECK:    n_state = ({15'b0, d, 17'b0} > r_prod) ? PS_TC : PS_ARMUL;
            PS_TC:       if (op_done) n_state = PS_FIN;
            PS_ARMUL:    n_state = PS_H;
            PS_H:        if (op_done) n_state = PS_DHMUL;
            PS_DHMUL:    n_state = PS_SQRT;
            PS_SQRT:     if (op_done) n_state = PS_TA1;
            PS_TA1:      if (op_done) n_state = PS_TD1;
            PS_TD1:      if (op_done) n_state = PS_FIN;
            PS_M1_MUL:   n_state = PS_M1_TA;
            PS_M1_TA:    if (op_done) n_state = PS_M1_CHECK;
            PS_M1_CHECK: n_state = (r_ta == '0 || r_td == '0) ? PS_FIN : PS_VC;
            PS_VC:       if (op_done) n_state = PS_ACC;
            PS_ACC:      if (op_done) n_state = PS_DEC;
            PS_DEC:      if (op_done) n_state = PS_FIN;
            PS_FIN:      n_state = PS_BASE1;
            PS_BASE1:    n_state = PS_BASE2;
            PS_BASE2:    n_state = PS_BASE3;
            PS_BASE3:    n_state = PS_IDLE;
            default:     n_state = PS_START;
        endcase
        if (cfg_wr) begin
            n_state = PS_START;
        end
    end

    // unit controls and operand selection
    always_comb begin
        is_div  = 1'b0;
        is_sqrt = 1'b0;
        is_mul  = 1'b0;
        div_dvd = '0;
        div_dvs = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            PS_TA0: begin
                is_div  = 1'b1;
                div_dvd = {17'b0, r_v, 16'b0};
                div_dvs = {1'b0, r_a};
            end
            PS_TD0: begin
                is_div  = 1'b1;
                div_dvd = {17'b0, r_v, 16'b0};
                div_dvs = {1'b0, r_r};
            end
            PS_SMUL: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, r_v};
                mul_b  = ta_plus_td;
            end
            PS_TC: begin
                is_div  = 1'b1;
                div_dvd = {15'b0, d, 17'b0} - r_prod;
                div_dvs = {r_v, 1'b0};
            end
            PS_ARMUL: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, r_a};
                mul_b  = {1'b0, r_r};
            end
            PS_H: begin
                is_div  = 1'b1;
                div_dvd = r_prod;
                div_dvs = a_plus_r;
            end
            PS_DHMUL: begin
                is_mul = 1'b1;
                mul_a  = d;
                mul_b  = {1'b0, r_h};
            end
            PS_SQRT: is_sqrt = 1'b1;
            PS_TA1: begin
                is_div  = 1'b1;
                div_dvd = {16'b0, r_vc, 16'b0};
                div_dvs = {1'b0, r_a};
            end
            PS_TD1: begin
                is_div  = 1'b1;
                div_dvd = {16'b0, r_vc, 16'b0};
                div_dvs = {1'b0, r_r};
            end
            PS_M1_MUL: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, r_v};
                mul_b  = {1'b0, r_a};
            end
            PS_M1_TA: begin
                is_div  = 1'b1;
                div_dvd = r_prod;
                div_dvs = a_plus_r;
            end
            PS_VC: begin
                is_div  = 1'b1;
                div_dvd = {15'b0, d, 17'b0};
                div_dvs = {1'b0, r_v} + {1'b0, r_tc};
            end
            PS_ACC: begin
                is_div  = 1'b1;
                div_dvd = {17'b0, r_vc[30:0], 16'b0};
                div_dvs = {1'b0, r_ta};
            end
            PS_DEC: begin
                is_div  = 1'b1;
                div_dvd = {17'b0, r_vc[30:0], 16'b0};
                div_dvs = {1'b0, r_td};
            end
            PS_BASE1: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, r_acc};
                mul_b  = {1'b0, r_ta};
            end
            PS_BASE2: begin
                is_mul = 1'b1;
                mul_a  = sat32u({16'b0, r_prod[63:16]});
                mul_b  = {1'b0, r_ta};
            end
            default: ;
        endcase
    end

    assign op_done = r_issued & ((is_div & div_done) | (is_sqrt & sqrt_done));

    // closing sums of the plan
    always_comb begin
        ds_sum  = {1'b0, r_ta} + {1'b0, r_tc};
        fin_ds  = ds_sum[31] ? MAX31 : ds_sum[30:0];
        tot_sum = {1'b0, fin_ds} + {1'b0, r_td};
        fin_tot = tot_sum[31] ? MAX31 : tot_sum[30:0];
        if (r_mode) begin
            fin_ds  = ds_sum[30:0];
            fin_tot = r_v;
        end
    end

    assign base_q = sat32u({16'b0, r_prod[63:16]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= PS_START;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr || op_done) begin
                r_issued <= 1'b0;
            end else if (is_div || is_sqrt) begin
                r_issued <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_mul) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (r_state)
            PS_START: begin
                r_err <= 1'b0;
                if (!r_mode) begin
                    if (r_a == '0 || r_r == '0 || r_v == '0) begin
                        r_err <= 1'b1;
                    end
                end else if (m1_fit) begin
                    r_ta <= r_a;
                    r_td <= r_r;
                    r_tc <= 31'(r_v - r_a - r_r);
                end
            end
            PS_TA0: if (op_done) r_ta <= q31;
            PS_TD0: if (op_done) r_td <= q31;
            PS_TC: begin
                if (op_done) begin
                    r_tc <= q31;
                    r_vc <= {1'b0, r_v};
                end
            end
            PS_H:    if (op_done) r_h <= div_q[30:0];
            PS_SQRT: if (op_done) r_vc <= sqrt_root;
            PS_TA1:  if (op_done) r_ta <= q31;
            PS_TD1: begin
                if (op_done) begin
                    r_td <= q31;
                    r_tc <= '0;
                    r_vc <= {1'b0, sat31({32'b0, r_vc})};
                end
            end
            PS_M1_TA: begin
                if (op_done) begin
                    r_ta <= div_q[30:0];
                    r_td <= r_v - div_q[30:0];
                    r_tc <= '0;
                end
            end
            PS_M1_CHECK: if (r_ta == '0 || r_td == '0) r_err <= 1'b1;
            PS_VC:  if (op_done) r_vc <= {1'b0, q31};
            PS_ACC: if (op_done) r_acc <= q31;
            PS_DEC: if (op_done) r_dec <= q31;
            PS_FIN: begin
                if (r_err) begin
                    r_ta  <= '0;
                    r_ds  <= '0;
                    r_tot <= '0;
                    r_acc <= '0;
                    r_dec <= '0;
                    r_vc  <= '0;
                end else begin
                    r_ds  <= fin_ds;
                    r_tot <= fin_tot;
                    if (!r_mode) begin
                        r_acc <= r_a;
                        r_dec <= r_r;
                    end
                end
            end
            PS_BASE3: r_base <= base_q[31:1];
            default: ;
        endcase
    end

    tmp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (is_div & ~r_issued & ~cfg_wr),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    tmp_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (is_sqrt & ~r_issued & ~cfg_wr),
        .i_radicand ({r_prod[62:0], 1'b0}),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    always_comb begin
        o_plan.ta   = r_ta;
        o_plan.ds   = r_ds;
        o_plan.tot  = r_tot;
        o_plan.acc  = r_acc;
        o_plan.dec  = r_dec;
        o_plan.vc   = r_vc[30:0];
        o_plan.base = r_base;
        o_plan.err  = r_err;
        o_plan.neg  = neg;
        o_plan.p0   = r_p0;
        o_plan.p1   = r_p1;
    end

    assign o_plan_ok = (r_state == PS_IDLE);

endmodule

### sv/tmp_eval.sv
// ----------------------------------------------------------------------------
// tmp_eval: six-stage sample evaluation pipeline
// Section decode, two chained Q16.16 products, offset, then saturated outputs.
// ----------------------------------------------------------------------------
module tmp_eval
    import tmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_plan     i_plan,
    input  logic      i_plan_ok,
    tmp_in_if.sink    i_sample,
    tmp_out_if.source o_result
);

    logic [6:1] r_v;
    logic [6:1] adv;
    logic       accept;

    // stage 1
    t_section    r1_sec;
    logic [30:0] r1_ct, r1_x, r1_y;
    // stage 2
    t_section    r2_sec;
    logic [30:0] r2_ct, r2_y;
    logic [61:0] r2_prod;
    // stage 3
    t_section    r3_sec;
    logic [30:0] r3_ct, r3_y;
    logic [31:0] r3_q1;
    // stage 4
    t_section    r4_sec;
    logic [30:0] r4_ct;
    logic [31:0] r4_q1;
    logic [62:0] r4_prod;
    // stage 5
    t_section    r5_sec;
    logic [30:0] r5_ct;
    logic [31:0] r5_vm, r5_off;
    // stage 6
    t_section    r6_sec;
    logic [30:0] r6_ct;
    logic [31:0] r6_pos, r6_vel, r6_acc;

    logic        t_pos;
    logic [30:0] ut;
    t_section    n1_sec;
    logic [30:0] n1_ct, n1_x, n1_y;

    logic [32:0] cruise_sum;
    logic [31:0] q2;
    logic [31:0] n5_off;

    logic signed [34:0] anchor, offx, pos_w, vel_w;
    logic               add_off;
    logic [31:0]        vel_mag;
    logic [30:0]        acc_mag;
    logic               acc_negate;
    logic [31:0]        n6_acc;

    always_comb begin
        adv[6] = ~r_v[6] | o_result.ready;
        adv[5] = ~r_v[5] | adv[6];
        adv[4] = ~r_v[4] | adv[5];
        adv[3] = ~r_v[3] | adv[4];
        adv[2] = ~r_v[2] | adv[3];
        adv[1] = ~r_v[1] | adv[2];
    end

    assign i_sample.ready = adv[1] & i_plan_ok;
    assign accept         = i_sample.valid & i_sample.ready;

    // section decode and multiplier operands
    always_comb begin
        t_pos = ~i_sample.sample_time[31] & (|i_sample.sample_time[30:0]);
        ut    = i_sample.sample_time[30:0];
        n1_x  = '0;
        n1_y  = '0;
        n1_ct = ut;
        priority if (!t_pos) begin
            n1_sec = SEC_BEFORE;
            n1_ct  = '0;
        end else if (ut < i_plan.ta) begin
            n1_sec = SEC_ACCEL;
            n1_x   = i_plan.acc;
            n1_y   = ut;
        end else if (ut <= i_plan.ds) begin
            n1_sec = SEC_CRUISE;
            n1_x   = i_plan.vc;
            n1_y   = ut - i_plan.ta;
        end else if (ut < i_plan.tot) begin
            n1_sec = SEC_DECEL;
            n1_x   = i_plan.dec;
            n1_y   = i_plan.tot - ut;
        end else begin
            n1_sec = SEC_DONE;
            n1_ct  = i_plan.tot;
        end
    end

    // offset from the second product, or accel part plus cruise distance
    always_comb begin
        cruise_sum = {2'b0, i_plan.base} + {1'b0, r4_q1};
        q2         = (|r4_prod[62:48]) ? 32'hFFFF_FFFF : r4_prod[47:16];
        if (r4_sec == SEC_CRUISE) begin
            n5_off = cruise_sum[32] ? 32'hFFFF_FFFF : cruise_sum[31:0];
        end else begin
            n5_off = {1'b0, q2[31:1]};
        end
    end

    // signed results
    always_comb begin
        anchor  = (r5_sec == SEC_DECEL || r5_sec == SEC_DONE) ?
                  35'(i_plan.p1) : 35'(i_plan.p0);
        offx    = (r5_sec == SEC_BEFORE || r5_sec == SEC_DONE) ?
                  35'sd0 : $signed({3'b000, r5_off});
        add_off = ((r5_sec == SEC_ACCEL || r5_sec == SEC_CRUISE) && !i_plan.neg) ||
                  (r5_sec == SEC_DECEL && i_plan.neg);
        pos_w   = add_off ? anchor + offx : anchor - offx;

        unique case (r5_sec)
            SEC_ACCEL, SEC_DECEL: vel_mag = r5_vm;
            SEC_CRUISE:           vel_mag = {1'b0, i_plan.vc};
            default:              vel_mag = '0;
        endcase
        vel_w = i_plan.neg ? -$signed({3'b000, vel_mag}) : $signed({3'b000, vel_mag});

        unique case (r5_sec)
            SEC_ACCEL: acc_mag = i_plan.acc;
            SEC_DECEL: acc_mag = i_plan.dec;
            default:   acc_mag = '0;
        endcase
        acc_negate = (r5_sec == SEC_ACCEL && i_plan.neg) ||
                     (r5_sec == SEC_DECEL && !i_plan.neg);
        n6_acc     = acc_negate ? 32'(-{1'b0, acc_mag}) : {1'b0, acc_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) r_v[1] <= accept;
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
            if (adv[4]) r_v[4] <= r_v[3];
            if (adv[5]) r_v[5] <= r_v[4];
            if (adv[6]) r_v[6] <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_sec <= n1_sec;
            r1_ct  <= n1_ct;
            r1_x   <= n1_x;
            r1_y   <= n1_y;
        end
        if (adv[2]) begin
            r2_sec  <= r1_sec;
            r2_ct   <= r1_ct;
            r2_y    <= r1_y;
            r2_prod <= {31'b0, r1_x} * {31'b0, r1_y};
        end
        if (adv[3]) begin
            r3_sec <= r2_sec;
            r3_ct  <= r2_ct;
            r3_y   <= r2_y;
            r3_q1  <= (|r2_prod[61:48]) ? 32'hFFFF_FFFF : r2_prod[47:16];
        end
        if (adv[4]) begin
            r4_sec  <= r3_sec;
            r4_ct   <= r3_ct;
            r4_q1   <= r3_q1;
            r4_prod <= {31'b0, r3_q1} * {32'b0, r3_y};
        end
        if (adv[5]) begin
            r5_sec <= r4_sec;
            r5_ct  <= r4_ct;
            r5_vm  <= r4_q1;
            r5_off <= n5_off;
        end
        if (adv[6]) begin
            r6_sec <= r5_sec;
            r6_ct  <= r5_ct;
            r6_pos <= sat32s(pos_w);
            r6_vel <= sat32s(vel_w);
            r6_acc <= n6_acc;
        end
    end

    always_comb begin
        o_result.valid          = r_v[6];
        o_result.position       = r6_pos;
        o_result.velocity       = r6_vel;
        o_result.accel_value    = r6_acc;
        o_result.clamped_time   = r6_ct;
        o_result.section        = r6_sec;
        o_result.total_duration = i_plan.tot;
        o_result.cruise_start   = i_plan.ta;
        o_result.decel_start    = i_plan.ds;
        o_result.plan_error     = i_plan.err;
    end

endmodule

### sv/trapezoidal_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile: Q16.16 trapezoidal motion profile generator
// Usage:
//   i_cfg: register writes (index, data). Always ready. Writes restart the
//     planner, which runs over a shared divider, a square root unit and a
//     multiplier. i_sample.ready stays low until the plan is done.
//   i_sample: one sample time per word. Once planned, a word can be taken
//     every cycle while o_result is not stalled.
//   o_result: one word per sample: position, velocity, acceleration, section,
//     clamped time, plan times and the error flag.
//   o_result.valid rises once the sample has passed the six-stage evaluation
//   pipeline (two chained products); throughput is one word per cycle
//   unless o_result stalls.
//   A stalled o_result holds its word; stages behind it keep filling empty
//   slots and then hold, so nothing is dropped or repeated.
//   Reset clears the configuration registers and pipeline valid flags to zero
//   and runs the planner once (the zero plan reports plan_error).
// ----------------------------------------------------------------------------
module trapezoidal_motion_profile
    import tmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmp_cfg_if.sink   i_cfg,
    tmp_in_if.sink    i_sample,
    tmp_out_if.source o_result
);

    t_plan plan;
    logic  plan_ok;

    tmp_plan u_plan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_plan    (plan),
        .o_plan_ok (plan_ok)
    );

    tmp_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_plan    (plan),
        .i_plan_ok (plan_ok),
        .i_sample  (i_sample),
        .o_result  (o_result)
    );

endmodule
